@@ design/drrn_pkg.sv @@
// Shared types and codes for the dual redundancy role negotiator.
// Used by drrn_eval, the top level and the port checker; no dependencies.
`default_nettype none

package drrn_pkg;

  typedef enum logic [2:0] {
    ROLE_IDLE    = 3'd0,
    ROLE_UNKNOWN = 3'd1,
    ROLE_ONLINE  = 3'd2,
    ROLE_HOT     = 3'd3,
    ROLE_COLD    = 3'd4
  } role_t;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_ROUND = 1'b1;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTNER_ID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_START  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 8'd3;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [31:0] own_id;
    logic [31:0] partner_id;
    logic [63:0] own_startup_ms;
    logic [31:0] lost_timeout_ms;
  } cfg_t;

  typedef struct packed {
    role_t       own_role;
    role_t       partner_role;
    logic        partner_degraded;
    logic [63:0] partner_startup;
    logic [63:0] last_seen_ms;
    logic        partner_seen;
  } state_t;

  typedef struct packed {
    logic        func;
    logic [63:0] now_ms;
    logic [63:0] partner_startup_ms;
    logic        partner_degraded_in;
    logic        own_link_full;
  } item_t;

  typedef struct packed {
    role_t own_role;
    role_t partner_role;
    logic  role_changed;
    role_t tx_role;
    logic  tx_degraded;
  } result_t;

endpackage

`default_nettype wire

@@ design/dual_redundancy_role_negotiator.sv @@
// Top level of the dual redundancy role negotiator: handshakes, config
// registers, item and result registers. Depends on drrn_pkg and drrn_eval.
//
// Every accepted item gives exactly one result item. An item is taken into an
// input register, evaluated by a single stage that reads and updates the
// negotiation state, and the result lands in an output register, which drives
// out_tvalid. One item per cycle is sustained while out_tready is high, set by
// that one evaluation stage with its state feedback. A result that waits on
// out_tready holds the pipe; the input register still takes one more item.
// Configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while no item is in flight; indexes above 3 are ignored.
`default_nettype none

module dual_redundancy_role_negotiator
  import drrn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [63:0] now_ms, [127:64] partner_startup_ms, [128] partner_degraded_in,
  // [129] own_link_full, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] func
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] own_role, [5:3] partner_role, [6] role_changed, [9:7] tx_role,
  // [10] tx_degraded, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]           cfg_data
);

  cfg_t    cfg_r;
  state_t  st_r, st_nxt;
  item_t   item_r;
  logic    item_vld_r;
  result_t res_r, res_nxt;
  logic    out_vld_r;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id          <= 32'd0;
      cfg_r.partner_id      <= 32'd1;
      cfg_r.own_startup_ms  <= 64'd0;
      cfg_r.lost_timeout_ms <= 32'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ID:     cfg_r.own_id          <= cfg_data[31:0];
        CFG_PARTNER_ID: cfg_r.partner_id      <= cfg_data[31:0];
        CFG_OWN_START:  cfg_r.own_startup_ms  <= cfg_data;
        CFG_TIMEOUT:    cfg_r.lost_timeout_ms <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func                <= in_tuser;
      item_r.now_ms              <= in_tdata[63:0];
      item_r.partner_startup_ms  <= in_tdata[127:64];
      item_r.partner_degraded_in <= in_tdata[128];
      item_r.own_link_full       <= in_tdata[129];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= '{own_role: ROLE_IDLE, partner_role: ROLE_IDLE,
                      partner_degraded: 1'b0, partner_startup: 64'd0,
                      last_seen_ms: 64'd0, partner_seen: 1'b0};
    end else begin
      if (in_tready) begin
        item_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  drrn_eval u_eval (
    .cfg  (cfg_r),
    .cur  (st_r),
    .item (item_r),
    .nxt  (st_nxt),
    .res  (res_nxt)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, res_r.tx_degraded, res_r.tx_role, res_r.role_changed,
                       res_r.partner_role, res_r.own_role};

endmodule

`default_nettype wire

@@ design/drrn_eval.sv @@
// Role evaluation for one item: next negotiator state and the result item.
// Purely combinational; depends on drrn_pkg.
`default_nettype none

module drrn_eval
  import drrn_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  logic [64:0] age;
  logic        backwards;
  logic        recent;
  logic        own_wins;
  logic        own_degraded;
  role_t       own_standby;
  role_t       partner_standby;

  always_comb begin
    age       = {1'b0, item.now_ms} - {1'b0, cur.last_seen_ms};
    backwards = age[64];
    recent    = cur.partner_seen && !backwards &&
                (age[63:0] < {32'd0, cfg.lost_timeout_ms});
    if (cfg.own_startup_ms != cur.partner_startup) begin
      own_wins = cfg.own_startup_ms < cur.partner_startup;
    end else begin
      own_wins = cfg.own_id < cfg.partner_id;
    end
    own_degraded    = !item.own_link_full;
    partner_standby = own_degraded ? ROLE_COLD : ROLE_HOT;
    own_standby     = cur.partner_degraded ? ROLE_COLD : ROLE_HOT;
  end

  always_comb begin
    nxt              = cur;
    res.role_changed = 1'b0;
    res.tx_role      = cur.own_role;
    res.tx_degraded  = 1'b0;
    if (item.func == FUNC_FRAME) begin
      nxt.partner_startup  = item.partner_startup_ms;
      nxt.partner_degraded = item.partner_degraded_in;
      nxt.last_seen_ms     = item.now_ms;
      nxt.partner_seen     = 1'b1;
    end else begin
      res.tx_degraded = own_degraded;
      if (!cur.partner_seen) begin
        nxt.partner_role = ROLE_IDLE;
      end else if (!recent) begin
        // lost partner; an online side keeps its role
        nxt.partner_role = ROLE_UNKNOWN;
        if (cur.own_role != ROLE_ONLINE) begin
          nxt.own_role = ROLE_UNKNOWN;
        end
      end else if (cur.own_role == ROLE_IDLE || cur.own_role == ROLE_UNKNOWN) begin
        if (own_wins) begin
          nxt.own_role     = ROLE_ONLINE;
          nxt.partner_role = partner_standby;
        end else begin
          nxt.own_role     = own_standby;
          nxt.partner_role = ROLE_ONLINE;
        end
      end else if (cur.own_role == ROLE_ONLINE) begin
        nxt.partner_role = partner_standby;
      end else begin
        nxt.own_role     = own_standby;
        nxt.partner_role = ROLE_ONLINE;
      end
      res.role_changed = (nxt.own_role != cur.own_role) ||
                         (nxt.partner_role != cur.partner_role);
    end
    res.own_role     = nxt.own_role;
    res.partner_role = nxt.partner_role;
  end

endmodule

`default_nettype wire

@@ design/drrn_checker.sv @@
// Port-level checks for the dual redundancy role negotiator, bound to the top.
// Depends on drrn_pkg.
`default_nettype none

module drrn_checker
  import drrn_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a held result must not change under backpressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // own role differing from the sent (old) role means a change was flagged
  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != out_tdata[9:7]) |-> out_tdata[6])
    else $error("own role changed without role_changed");

  // both sides never online at once
  a_single_online: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ROLE_ONLINE) |-> (out_tdata[5:3] != ROLE_ONLINE))
    else $error("both channels online");

endmodule

bind dual_redundancy_role_negotiator drrn_checker u_drrn_checker (.*);

`default_nettype wire
